FILE: rtl/tsln_pkg.sv
// tsln_pkg: shared constants, register codes and byte rendering for the
// text stream line number / show nonprint filter. No dependencies.
package tsln_pkg;

	// Line number field
	localparam int unsigned DefaultDigits = 6;
	localparam int unsigned FieldCap      = 7;
	localparam int unsigned CountMax      = 1048575;   // largest 20-bit count
	localparam int unsigned BodyMax       = 4;         // M-^X is the longest body

	// Character codes
	localparam logic [7:0] CHR_TAB    = 8'h09;
	localparam logic [7:0] CHR_NL     = 8'h0A;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_DOLLAR = 8'h24;
	localparam logic [7:0] CHR_DASH   = 8'h2D;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_CAPI   = 8'h49;
	localparam logic [7:0] CHR_CAPM   = 8'h4D;
	localparam logic [7:0] CHR_CARET  = 8'h5E;
	localparam logic [7:0] DEL_CODE   = 8'd127;
	localparam logic [7:0] CARET_OFS  = 8'd64;

	// Numbering modes (code 3 behaves as off)
	localparam logic [1:0] MODE_OFF      = 2'd0;
	localparam logic [1:0] MODE_ALL      = 2'd1;
	localparam logic [1:0] MODE_NONEMPTY = 2'd2;
	localparam logic [1:0] MODE_SPARE    = 2'd3;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_NUMBER_MODE   = 3'd0,
		REG_SQUEEZE_BLANK = 3'd1,
		REG_SHOW_ENDS     = 3'd2,
		REG_SHOW_TABS     = 3'd3,
		REG_SHOW_NONPRINT = 3'd4
	} cfg_reg_t;

	// Rendered body of one byte
	typedef struct packed {
		logic [BodyMax-1:0][7:0] b;
		logic [2:0]              len;
	} body_t;

	// Render a 7-bit value as control, DEL or printable form
	function automatic body_t render_low(input logic [6:0] c, input body_t pre,
			input logic [1:0] at);
		body_t r;
		r = pre;
		if (c < 7'd32) begin
			r.b[at]        = CHR_CARET;
			r.b[at + 2'd1] = {1'b0, c} + CARET_OFS;
			r.len          = 3'({1'b0, at}) + 3'd2;
		end else if ({1'b0, c} == DEL_CODE) begin
			r.b[at]        = CHR_CARET;
			r.b[at + 2'd1] = {1'b0, c} - CARET_OFS;
			r.len          = 3'({1'b0, at}) + 3'd2;
		end else begin
			r.b[at] = {1'b0, c};
			r.len   = 3'({1'b0, at}) + 3'd1;
		end
		return r;
	endfunction

	// Render one input byte under the tab and nonprint options
	function automatic body_t render_body(input logic [7:0] c, input logic tabs,
			input logic nonprint);
		body_t r;
		r = '0;
		if (c == CHR_TAB) begin
			if (tabs) begin
				r.b[0] = CHR_CARET;
				r.b[1] = CHR_CAPI;
				r.len  = 3'd2;
			end else begin
				r.b[0] = CHR_TAB;
				r.len  = 3'd1;
			end
		end else if (c == CHR_NL || !nonprint) begin
			r.b[0] = c;
			r.len  = 3'd1;
		end else if (c[7]) begin
			r.b[0] = CHR_CAPM;
			r.b[1] = CHR_DASH;
			r      = render_low(c[6:0], r, 2'd2);
		end else begin
			r = render_low(c[6:0], r, 2'd0);
		end
		return r;
	endfunction

endpackage

FILE: rtl/text_stream_line_number_show_nonprint_unit.sv
// Text stream filter top level: numbering, blank squeezing, end marks and
// visible control bytes. Depends on tsln_pkg.
//
// Usage:
//   s_axis carries one text byte per word (tdata = in_byte, tuser = file_start).
//   m_axis carries the expanded text, one byte per word (tdata = out_byte);
//   tlast marks the final byte produced by one input word.
//   The APB port holds five option registers at byte addresses 0,4,8,12,16:
//   number_mode, squeeze_blank, show_ends, show_tabs, show_nonprint.
// Flow:
//   An accepted word is held in the input register until the output shift
//   register is free, is expanded in one pass into that register, and its
//   first byte is then shown on m_axis. The output shift register sends one
//   byte per cycle while m_axis_tready is high; an item expands to 1 to 11
//   bytes with six digits (field width plus one extra for a number or blank
//   field); a squeezed newline shows nothing. The next word loads as the
//   last byte leaves.
// Reset and stall:
//   Reset clears options, sets the line count to one and marks a line start.
//   When m_axis stalls the current byte holds; one further input word is
//   taken into the input register, then s_axis_tready drops.
module text_stream_line_number_show_nonprint_unit #(
	parameter int unsigned NUMBER_DIGITS = tsln_pkg::DefaultDigits
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic [0:0]  s_axis_tuser,   // [0] file_start
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned FW = (NUMBER_DIGITS < 1) ? 1 :
		((NUMBER_DIGITS > tsln_pkg::FieldCap) ? tsln_pkg::FieldCap : NUMBER_DIGITS);
	localparam int unsigned LimV = ((10 ** FW) - 1 > tsln_pkg::CountMax) ?
		tsln_pkg::CountMax : (10 ** FW) - 1;
	localparam int unsigned PreLen = FW + 1;
	localparam int unsigned MaxRun = PreLen + tsln_pkg::BodyMax;
	localparam int unsigned RemW   = $clog2(MaxRun + 1);
	localparam int unsigned CntW   = 4 * FW;

	// option registers
	logic [1:0] number_mode_q;
	logic       squeeze_blank_q;
	logic       show_ends_q;
	logic       show_tabs_q;
	logic       show_nonprint_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	// line state
	logic [FW-1:0][3:0] count_q;
	logic [1:0]         nlrun_q;

	// output shift register
	logic [MaxRun-1:0][7:0] run_q;
	logic [RemW-1:0]        rem_q;

	logic [FW-1:0][3:0] lim_dig;
	logic [FW-1:0][3:0] cnt_eff;
	logic [FW-1:0][3:0] cnt_inc;
	logic [FW-1:0][3:0] cnt_next;
	logic [1:0]         run_eff;
	logic [1:0]         nlrun_next;
	logic               is_nl;
	logic               at_start;
	logic               squeezed;
	logic               num_on;
	logic               blank_on;
	logic               dol_on;
	logic               cnt_sat;
	logic [FW-1:0]      digit_blank;
	logic [PreLen-1:0][7:0]  pre;
	logic [MaxRun-1:0][7:0]  run_d;
	logic [RemW-1:0]         len_d;
	tsln_pkg::body_t         body;
	logic               buf_free;
	logic               advance;
	logic               cfg_wr;
	tsln_pkg::cfg_reg_t cfg_sel;

	// limit digits, worked out at elaboration
	for (genvar g = 0; g < FW; g++) begin : g_lim
		localparam logic [3:0] LD = 4'((LimV / (10 ** g)) % 10);
		assign lim_dig[g] = LD;
	end

	// configuration port
	assign pready  = 1'b1;
	assign cfg_sel = tsln_pkg::cfg_reg_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_mode_q   <= tsln_pkg::MODE_OFF;
			squeeze_blank_q <= 1'b0;
			show_ends_q     <= 1'b0;
			show_tabs_q     <= 1'b0;
			show_nonprint_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				tsln_pkg::REG_NUMBER_MODE:   number_mode_q   <= pwdata[1:0];
				tsln_pkg::REG_SQUEEZE_BLANK: squeeze_blank_q <= pwdata[0];
				tsln_pkg::REG_SHOW_ENDS:     show_ends_q     <= pwdata[0];
				tsln_pkg::REG_SHOW_TABS:     show_tabs_q     <= pwdata[0];
				tsln_pkg::REG_SHOW_NONPRINT: show_nonprint_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			tsln_pkg::REG_NUMBER_MODE:   prdata = {30'd0, number_mode_q};
			tsln_pkg::REG_SQUEEZE_BLANK: prdata = {31'd0, squeeze_blank_q};
			tsln_pkg::REG_SHOW_ENDS:     prdata = {31'd0, show_ends_q};
			tsln_pkg::REG_SHOW_TABS:     prdata = {31'd0, show_tabs_q};
			tsln_pkg::REG_SHOW_NONPRINT: prdata = {31'd0, show_nonprint_q};
			default:                     prdata = '0;
		endcase
	end

	// handshakes
	assign m_axis_tvalid = (rem_q != '0);
	assign m_axis_tlast  = (rem_q == RemW'(1));
	assign m_axis_tdata  = run_q[0];
	assign buf_free      = (rem_q == '0) || (m_axis_tready && m_axis_tlast);
	assign advance       = valid_s1 && buf_free;
	assign s_axis_tready = !valid_s1 || advance;

	// hold the accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser[0];
		end
	end

	// line state seen by this word, after a file restart
	always_comb begin
		cnt_eff = count_q;
		run_eff = nlrun_q;
		if (first_s1) begin
			cnt_eff    = '0;
			cnt_eff[0] = 4'd1;
			run_eff    = 2'd1;
		end
		is_nl    = (byte_s1 == tsln_pkg::CHR_NL);
		at_start = (run_eff != 2'd0);
		squeezed = is_nl && squeeze_blank_q && (run_eff == 2'd2);
		num_on   = at_start && ((number_mode_q == tsln_pkg::MODE_ALL) ||
			(number_mode_q == tsln_pkg::MODE_NONEMPTY && !is_nl));
		dol_on   = is_nl && show_ends_q;
		blank_on = dol_on && at_start && (number_mode_q == tsln_pkg::MODE_NONEMPTY);
		cnt_sat  = (cnt_eff == lim_dig);
	end

	// decimal increment of the line count
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int i = 0; i < FW; i++) begin
			if (carry && cnt_eff[i] == 4'd9) begin
				cnt_inc[i] = 4'd0;
			end else begin
				cnt_inc[i] = cnt_eff[i] + 4'(carry);
				carry      = 1'b0;
			end
		end
		cnt_next   = (num_on && !cnt_sat) ? cnt_inc : cnt_eff;
		nlrun_next = is_nl ? ((run_eff == 2'd2) ? 2'd2 : run_eff + 2'd1) : 2'd0;
	end

	// number field: leading zeros shown as spaces, units always shown unless the field is blank
	always_comb begin
		logic upper_zero;
		upper_zero = 1'b1;
		for (int j = FW - 1; j >= 0; j--) begin
			upper_zero     = upper_zero && (cnt_eff[j] == 4'd0);
			digit_blank[j] = upper_zero && (j != 0);
		end
		for (int k = 0; k < FW; k++) begin
			if (blank_on || digit_blank[FW-1-k]) begin
				pre[k] = tsln_pkg::CHR_SPACE;
			end else begin
				pre[k] = tsln_pkg::CHR_ZERO + {4'd0, cnt_eff[FW-1-k]};
			end
		end
		pre[FW] = tsln_pkg::CHR_TAB;
	end

	// assemble the byte run: prefix, end mark, body
	always_comb begin
		int p;
		int d;
		int k;
		body = tsln_pkg::render_body(byte_s1, show_tabs_q, show_nonprint_q);
		p    = (num_on || blank_on) ? PreLen : 0;
		d    = dol_on ? 1 : 0;
		for (int i = 0; i < MaxRun; i++) begin
			k = i - p - d;
			if (i < p) begin
				run_d[i] = pre[i];
			end else if (i == p && dol_on) begin
				run_d[i] = tsln_pkg::CHR_DOLLAR;
			end else if (k >= 0 && k < tsln_pkg::BodyMax) begin
				run_d[i] = body.b[k[1:0]];
			end else begin
				run_d[i] = 8'd0;
			end
		end
		len_d = squeezed ? '0 : RemW'(p + d) + RemW'(body.len);
	end

	// advance line state when a word is expanded and not squeezed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CntW'(1);
			nlrun_q <= 2'd1;
		end else if (advance && !squeezed) begin
			count_q <= cnt_next;
			nlrun_q <= nlrun_next;
		end
	end

	// load or shift the output run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (advance) begin
			rem_q <= len_d;
		end else if (m_axis_tvalid && m_axis_tready) begin
			rem_q <= rem_q - RemW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			run_q <= run_d;
		end else if (m_axis_tvalid && m_axis_tready) begin
			for (int i = 0; i < MaxRun - 1; i++) begin
				run_q[i] <= run_q[i+1];
			end
			run_q[MaxRun-1] <= 8'd0;
		end
	end

endmodule

FILE: rtl/tsln_checker.sv
// tsln_checker: port-level assertions for the text stream filter, bound
// to text_stream_line_number_show_nonprint_unit. No package dependency.
module tsln_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       pready
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
		$stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output word changed");

	// no output word in the first cycle out of reset
	a_reset_idle: assert property (@(posedge clk) $rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

	// an empty output side never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// input is taken while the last byte of a run leaves
	a_ready_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |-> s_axis_tready)
		else $error("input stalled as run completed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port not ready");

endmodule

bind text_stream_line_number_show_nonprint_unit tsln_checker u_tsln_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.pready        (pready)
);
